// ===== src/idq_pkg.sv =====
// Shared types and constants for the indexed deque.
package idq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned OpW      = 3;
  localparam int unsigned PosW     = 5;
  localparam int unsigned DataIoW  = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountIoW = 5;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ       = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Source of the target index for a shift or take
  typedef enum logic [1:0] {
    AT_COUNT,
    AT_ZERO,
    AT_POS,
    AT_LAST
  } at_sel_e;

  // Memory read address relative to the pointer
  typedef enum logic [1:0] {
    RD_PREV,
    RD_PTR,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    logic    load_up;
    logic    load_take;
    at_sel_e at_sel;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_word;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    grab;
    logic    load_out;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic in_range;
    logic up_done;
    logic dn_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/idq_if.sv =====
// Request and response channel interfaces of the indexed deque.
interface idq_req_if;
  logic                              valid;
  logic                              ready;
  logic [idq_pkg::OpW-1:0]           op;
  logic signed [idq_pkg::PosW-1:0]   position;
  logic [idq_pkg::DataIoW-1:0]       data_in;

  modport source(output valid, op, position, data_in, input ready);
  modport sink(input valid, op, position, data_in, output ready);
endinterface

interface idq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [idq_pkg::DataIoW-1:0]       data_out;
  logic [idq_pkg::StatusW-1:0]       status;
  logic [idq_pkg::CountIoW-1:0]      count;

  modport source(output valid, data_out, status, count, input ready);
  modport sink(input valid, data_out, status, count, output ready);
endinterface

// ===== src/idq_datapath.sv =====
// Datapath: entry memory, count, shift pointer and result register.
module idq_datapath #(
  parameter int unsigned DEPTH      = idq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = idq_pkg::DataWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  idq_pkg::dp_cmd_t                   cmd_i,
  output idq_pkg::dp_sts_t                   sts_o,
  input  logic [idq_pkg::OpW-1:0]            op_i,
  input  logic signed [idq_pkg::PosW-1:0]    position_i,
  input  logic [idq_pkg::DataIoW-1:0]        data_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [idq_pkg::DataIoW-1:0]        data_out_o,
  output logic [idq_pkg::StatusW-1:0]        status_o,
  output logic [idq_pkg::CountIoW-1:0]       count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = (CW + 1 > idq_pkg::PosW) ? CW + 1 : idq_pkg::PosW;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  idq_pkg::op_e                 op_q;
  logic signed [idq_pkg::PosW-1:0] pos_q;
  logic [DATA_WIDTH-1:0]        word_q;
  logic [DATA_WIDTH-1:0]        word_in;
  logic [DATA_WIDTH-1:0]        dout_q;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                at_q, at_d;
  logic [CW-1:0]                at_val;
  logic [CW-1:0]                rd_idx;
  logic                         out_valid_q;
  logic [DATA_WIDTH-1:0]        out_data_q;
  idq_pkg::status_e             out_status_q;
  logic [CW-1:0]                out_count_q;

  logic signed [PW-1:0] pos_ext, cnt_s, pos_adj, pos_res;
  logic [CW-1:0]        rpos;

  if (DATA_WIDTH <= idq_pkg::DataIoW) begin : g_in_narrow
    assign word_in = data_in_i[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign word_in = {{(DATA_WIDTH - idq_pkg::DataIoW){1'b0}}, data_in_i};
  end

  if (DATA_WIDTH >= idq_pkg::DataIoW) begin : g_out_wide
    assign data_out_o = out_data_q[idq_pkg::DataIoW-1:0];
  end else begin : g_out_narrow
    assign data_out_o = {{(idq_pkg::DataIoW - DATA_WIDTH){1'b0}}, out_data_q};
  end

  if (CW >= idq_pkg::CountIoW) begin : g_cnt_wide
    assign count_o = out_count_q[idq_pkg::CountIoW-1:0];
  end else begin : g_cnt_narrow
    assign count_o = {{(idq_pkg::CountIoW - CW){1'b0}}, out_count_q};
  end

  // Negative positions count from the end; still negative clamps to zero
  always_comb begin
    pos_ext = PW'(pos_q);
    cnt_s   = signed'(PW'(count_q));
    pos_adj = pos_ext[PW-1] ? pos_ext + cnt_s : pos_ext;
    pos_res = pos_adj[PW-1] ? '0 : pos_adj;
    rpos    = pos_res[CW-1:0];
  end

  always_comb begin
    unique case (cmd_i.at_sel)
      idq_pkg::AT_COUNT: at_val = count_q;
      idq_pkg::AT_ZERO:  at_val = '0;
      idq_pkg::AT_POS:   at_val = rpos;
      idq_pkg::AT_LAST:  at_val = count_q - CW'(1);
      default:           at_val = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      idq_pkg::RD_PREV: rd_idx = ptr_q - CW'(1);
      idq_pkg::RD_PTR:  rd_idx = ptr_q;
      idq_pkg::RD_NEXT: rd_idx = ptr_q + CW'(1);
      default:          rd_idx = ptr_q;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    at_d  = at_q;
    priority if (cmd_i.load_up) begin
      at_d  = at_val;
      ptr_d = count_q;
    end else if (cmd_i.load_take) begin
      ptr_d = at_val;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.empty    = (count_q == '0);
    sts_o.full     = (count_q == CW'(DEPTH));
    sts_o.in_range = (pos_res < cnt_s);
    sts_o.up_done  = (ptr_q == at_q);
    sts_o.dn_done  = ({1'b0, ptr_q} + (CW + 1)'(1) >= {1'b0, count_q});
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= cmd_i.wr_word ? word_q : rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= idq_pkg::op_e'(op_i);
      pos_q  <= position_i;
      word_q <= word_in;
    end
    if (cmd_i.capture) begin
      dout_q <= '0;
    end else if (cmd_i.grab) begin
      dout_q <= rdata_q;
    end
    if (cmd_i.load_out) begin
      out_data_q   <= dout_q;
      out_status_q <= cmd_i.status;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      at_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      at_q    <= at_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

endmodule

// ===== src/idq_ctrl.sv =====
// Controller: sequences decode, entry shifts and result hand-off.
module idq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  idq_pkg::dp_sts_t sts_i,
  output idq_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_UP_WR,
    S_TAKE_RD,
    S_TAKE_WAIT,
    S_DN,
    S_DN_WR,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  idq_pkg::status_e  st_q, st_d;
  logic              ready_q;

  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    cmd_o         = '0;
    cmd_o.at_sel  = idq_pkg::AT_ZERO;
    cmd_o.rd_sel  = idq_pkg::RD_PTR;
    cmd_o.status  = st_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = idq_pkg::ST_OK;
        state_d = S_RESP;
        unique case (sts_i.op)
          idq_pkg::OP_PUSH_BACK, idq_pkg::OP_PUSH_FRONT: begin
            if (sts_i.full) begin
              st_d = idq_pkg::ST_FULL;
            end else begin
              cmd_o.load_up = 1'b1;
              cmd_o.at_sel  = (sts_i.op == idq_pkg::OP_PUSH_BACK) ?
                              idq_pkg::AT_COUNT : idq_pkg::AT_ZERO;
              state_d       = S_UP;
            end
          end
          idq_pkg::OP_INSERT: begin
            // range is checked before fullness
            priority if (!sts_i.in_range) begin
              st_d = idq_pkg::ST_RANGE;
            end else if (sts_i.full) begin
              st_d = idq_pkg::ST_FULL;
            end else begin
              cmd_o.load_up = 1'b1;
              cmd_o.at_sel  = idq_pkg::AT_POS;
              state_d       = S_UP;
            end
          end
          idq_pkg::OP_POP_BACK, idq_pkg::OP_POP_FRONT: begin
            if (sts_i.empty) begin
              st_d = idq_pkg::ST_EMPTY;
            end else begin
              cmd_o.load_take = 1'b1;
              cmd_o.at_sel    = (sts_i.op == idq_pkg::OP_POP_BACK) ?
                                idq_pkg::AT_LAST : idq_pkg::AT_ZERO;
              state_d         = S_TAKE_RD;
            end
          end
          idq_pkg::OP_REMOVE, idq_pkg::OP_READ: begin
            priority if (sts_i.empty) begin
              st_d = idq_pkg::ST_EMPTY;
            end else if (!sts_i.in_range) begin
              st_d = idq_pkg::ST_RANGE;
            end else begin
              cmd_o.load_take = 1'b1;
              cmd_o.at_sel    = idq_pkg::AT_POS;
              state_d         = S_TAKE_RD;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_UP: begin
        // open the gap from the top down, then drop the new word in
        if (sts_i.up_done) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_word = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = idq_pkg::RD_PREV;
          state_d      = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_UP;
      end
      S_TAKE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = idq_pkg::RD_PTR;
        state_d      = S_TAKE_WAIT;
      end
      S_TAKE_WAIT: begin
        cmd_o.grab = 1'b1;
        state_d    = (sts_i.op == idq_pkg::OP_READ) ? S_RESP : S_DN;
      end
      S_DN: begin
        if (sts_i.dn_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = idq_pkg::RD_NEXT;
          state_d      = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DN;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= idq_pkg::ST_OK;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ===== src/indexed_deque.sv =====
// Indexed deque: one operation at a time on an entry memory with one write port and one
// registered read port. Every entry shifted to open or close a gap (push front, insert,
// pop front, remove) takes a read state and then a write state, as the memory's read
// data is registered.
// A result waits in an output register, and the next item is accepted meanwhile.
module indexed_deque #(
  parameter int unsigned DEPTH      = idq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = idq_pkg::DataWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  idq_req_if.sink     req_i,
  idq_rsp_if.source   rsp_o
);

  idq_pkg::dp_cmd_t cmd;
  idq_pkg::dp_sts_t sts;

  idq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (req_i.op),
    .position_i  (req_i.position),
    .data_in_i   (req_i.data_in),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .data_out_o  (rsp_o.data_out),
    .status_o    (rsp_o.status),
    .count_o     (rsp_o.count)
  );

endmodule

// ===== src/idq_checker.sv =====
// Port-level checks for the indexed deque, bound to the top level.
module idq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [idq_pkg::DataIoW-1:0]       rsp_data_i,
  input logic [idq_pkg::StatusW-1:0]       rsp_status_i,
  input logic [idq_pkg::CountIoW-1:0]      rsp_count_i
);

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous item still in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i)
      && $stable(rsp_status_i) && $stable(rsp_count_i))
    else $error("stalled response changed");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != idq_pkg::ST_OK |-> rsp_data_i == '0)
    else $error("refused item returned data");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == idq_pkg::ST_EMPTY |-> rsp_count_i == '0)
    else $error("empty status with nonzero count");

endmodule

bind indexed_deque idq_checker u_idq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_data_i   (rsp_o.data_out),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);

// ===== tb/indexed_deque_test.sv =====
// Self-checking testbench for the indexed deque: directed edge cases, random traffic, backpressure.
`timescale 1ns / 1ps

module indexed_deque_test;
  import idq_pkg::*;

  localparam logic [OpW-1:0] OpNoop = 3'd7;  // unused op code
  localparam int unsigned Depth = DepthDefault;
  localparam int unsigned DrainCycles = 40;  // longest shift plus output register

  typedef struct {
    logic [DataIoW-1:0]  data;
    status_e             status;
    logic [CountIoW-1:0] count;
  } deque_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  idq_req_if req ();
  idq_rsp_if rsp ();

  indexed_deque dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the deque
  logic [DataIoW-1:0] shadow_words[Depth];
  int unsigned        shadow_count;
  deque_rsp_t         expected_q[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic int unsigned resolve_index(logic signed [PosW-1:0] pos);
    int p;
    p = pos;
    if (p < 0) p += shadow_count;
    if (p < 0) p = 0;
    return p;
  endfunction

  function automatic void open_gap(int unsigned at, logic [DataIoW-1:0] word);
    for (int i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[at] = word;
    shadow_count++;
  endfunction

  function automatic logic [DataIoW-1:0] close_gap(int unsigned at);
    logic [DataIoW-1:0] w;
    w = shadow_words[at];
    for (int i = at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return w;
  endfunction

  function automatic deque_rsp_t deque_apply(logic [OpW-1:0] op, logic signed [PosW-1:0] pos,
                                             logic [DataIoW-1:0] word);
    deque_rsp_t  r;
    int unsigned at;
    r.data = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_count >= Depth) r.status = ST_FULL;
        else open_gap(op == OP_PUSH_BACK ? shadow_count : 0, word);
      end
      OP_INSERT: begin
        at = resolve_index(pos);
        // range is checked before fullness
        if (at >= shadow_count) r.status = ST_RANGE;
        else if (shadow_count >= Depth) r.status = ST_FULL;
        else open_gap(at, word);
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.data = close_gap(op == OP_POP_BACK ? shadow_count - 1 : 0);
      end
      OP_REMOVE, OP_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at = resolve_index(pos);
          if (at >= shadow_count) r.status = ST_RANGE;
          else if (op == OP_REMOVE) r.data = close_gap(at);
          else r.data = shadow_words[at];
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CountIoW-1:0];
    return r;
  endfunction

  // Called at a rising edge; returns at the rising edge after the item and any idle gap.
  task automatic send_item(logic [OpW-1:0] op, logic signed [PosW-1:0] pos,
                           logic [DataIoW-1:0] word);
    int gap;
    req.valid <= 1'b1;
    req.op <= op;
    req.position <= pos;
    req.data_in <= word;
    do @(negedge clk_i); while (req.ready !== 1'b1);
    @(posedge clk_i);
    expected_q.push_back(deque_apply(op, pos, word));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    @(posedge clk_i);
  endtask

  // mostly positions that hit stored entries, from either end
  function automatic logic signed [PosW-1:0] pick_position();
    int idx;
    if (shadow_count > 0 && $urandom_range(99) < 75) begin
      idx = $urandom_range(0, 2 * shadow_count - 1);
      if (idx >= shadow_count) idx -= 2 * shadow_count;
      return PosW'(idx);
    end
    return PosW'($urandom_range(0, 31));
  endfunction

  task automatic random_item(int fill_pct);
    int r;
    logic [OpW-1:0] op;
    r = $urandom_range(99);
    if (r < 3) begin
      op = OpNoop;
    end else if (r < 15) begin
      op = OP_READ;
    end else if ($urandom_range(99) < fill_pct) begin
      case ($urandom_range(2))
        0: op = OP_PUSH_BACK;
        1: op = OP_PUSH_FRONT;
        default: op = OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: op = OP_POP_BACK;
        1: op = OP_POP_FRONT;
        default: op = OP_REMOVE;
      endcase
    end
    send_item(op, pick_position(), $urandom());
  endtask

  task automatic test_empty_store();
    send_item(OP_POP_BACK, 5'sd0, 32'h0);
    send_item(OP_POP_FRONT, 5'sd0, 32'h0);
    send_item(OP_REMOVE, 5'sd0, 32'h0);
    send_item(OP_READ, -5'sd1, 32'h0);
    send_item(OP_INSERT, 5'sd0, 32'h1234_5678);  // out of range when empty
    send_item(OpNoop, 5'sd0, 32'hffff_ffff);
  endtask

  task automatic test_positions();
    send_item(OP_PUSH_BACK, 5'sd0, 32'hffff_ffff);
    send_item(OP_PUSH_FRONT, 5'sd0, 32'h0000_0000);
    send_item(OP_INSERT, 5'sd1, 32'ha5a5_a5a5);
    send_item(OP_INSERT, -5'sd16, 32'h5a5a_5a5a);   // clamps to the front
    send_item(OP_INSERT, -5'sd1, 32'h0f0f_0f0f);
    send_item(OP_INSERT, 5'sd15, 32'hdead_beef);    // past the end
    send_item(OP_READ, 5'sd15, 32'h0);
    send_item(OP_READ, -5'sd1, 32'h0);
    send_item(OP_READ, -5'sd16, 32'h0);
    send_item(OP_REMOVE, 5'sd2, 32'h0);
    send_item(OP_REMOVE, -5'sd16, 32'h0);
    send_item(OP_REMOVE, 5'sd15, 32'h0);
    send_item(OpNoop, -5'sd1, 32'h0);
    wait_drained();
  endtask

  task automatic test_full_store();
    while (shadow_count < Depth) send_item(OP_PUSH_BACK, 5'sd0, $urandom());
    send_item(OP_PUSH_BACK, 5'sd0, 32'hffff_ffff);
    send_item(OP_PUSH_FRONT, 5'sd0, 32'hffff_ffff);
    send_item(OP_INSERT, 5'sd0, 32'hffff_ffff);
    send_item(OP_INSERT, -5'sd1, 32'hffff_ffff);
    send_item(OP_READ, 5'sd15, 32'h0);
    send_item(OP_READ, -5'sd16, 32'h0);
    send_item(OP_REMOVE, 5'sd15, 32'h0);
    send_item(OP_INSERT, 5'sd15, 32'h8000_0001);  // one slot free again
    while (shadow_count > 0) send_item($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK,
                                       5'sd0, 32'h0);
    wait_drained();
  endtask

  // blocks that lean toward filling, then toward emptying
  task automatic test_random_mix(int send_pct, int recv_pct, int n_items);
    set_idling(send_pct, recv_pct);
    for (int i = 0; i < n_items; i++) random_item((i / 40) % 2 == 0 ? 70 : 30);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    @(negedge clk_i);
    hold_left = 400;
    @(posedge clk_i);
    for (int i = 0; i < 40; i++) random_item(60);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // both handshake signals are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin : check_results
    deque_rsp_t want;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, data %h", rsp.data_out));
      end else begin
        want = expected_q.pop_front();
        if (rsp.data_out !== want.data)
          report_mismatch($sformatf("data_out %h, expected %h", rsp.data_out, want.data));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", rsp.status, want.status.name()));
        if (rsp.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", rsp.count, want.count));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("indexed_deque regression: fail");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.op = OP_PUSH_BACK;
    req.position = '0;
    req.data_in = '0;
    rsp.ready = 1'b0;
    shadow_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_positions();
    test_full_store();
    test_random_mix(0, 0, 140);
    test_random_mix(84, 0, 130);
    test_random_mix(0, 84, 130);
    test_random_mix(21, 21, 140);
    test_backpressure();

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    $display("%0d operations sent, %0d results checked under four idling mixes,",
             items_sent, results_seen);
    $display("including empty and full stores, both position signs and a long output stall");
    if (errors == 0) begin
      $display("indexed_deque regression: pass");
    end else begin
      $display("indexed_deque regression: fail");
    end
    $finish;
  end

endmodule
